/* rtl/core/tsc_pkg.sv */
`default_nettype none

package tsc_pkg;

  // Fixed field widths
  localparam int ANGLE_W   = 32;
  localparam int VALUE_W   = 40;
  localparam int TERM_W    = 4;

  // Term magnitudes stay below 2^41; a term reaching that bound saturates
  localparam int MAG_W     = 41;
  // Running sum of at most ten terms below 2^41
  localparam int ACC_W     = 46;

  // Shared multiplier operand width
  localparam int MUL_W     = 32;

  // Divider: largest divisor is 18*19 = 342
  localparam int DIVISOR_W = 9;
  localparam int DIGIT_W   = 8;
  localparam int DIV_W     = 56;
  localparam int DIV_STEPS = DIV_W / DIGIT_W;

  // Series divisor for term k: sine (2k-2)(2k-1), cosine (2k-3)(2k-2)
  function automatic logic [DIVISOR_W-1:0] series_divisor(input logic [TERM_W-1:0] k,
                                                          input logic cosine);
    logic [TERM_W:0]      a;
    logic [2*TERM_W+1:0]  pr;
    a  = cosine ? ({k, 1'b0} - (TERM_W+1)'(3)) : ({k, 1'b0} - (TERM_W+1)'(2));
    pr = (2*TERM_W+2)'(a) * (2*TERM_W+2)'(a + (TERM_W+1)'(1));
    return pr[DIVISOR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tsc_mul.sv */
`default_nettype none

module tsc_mul import tsc_pkg::*; (
  input  wire                  clk,
  input  wire  [MUL_W-1:0]     a,
  input  wire  [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   p
);

  logic [2*MUL_W-1:0] p_r;

  // Unsigned 32x32 product, registered
  always_ff @(posedge clk) begin
    p_r <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* rtl/core/tsc_div_step.sv */
`default_nettype none

module tsc_div_step import tsc_pkg::*; (
  input  wire  [DIVISOR_W-1:0] rem_in,
  input  wire  [DIGIT_W-1:0]   bits_in,
  input  wire  [DIVISOR_W-1:0] divisor,
  output logic [DIVISOR_W-1:0] rem_out,
  output logic [DIGIT_W-1:0]   q_out
);

  logic [DIVISOR_W-1:0] r;
  logic [DIVISOR_W:0]   t;

  // Restoring division, one quotient digit of DIGIT_W bits, MSB first
  always_comb begin
    r     = rem_in;
    t     = '0;
    q_out = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, bits_in[i]};
      if (t >= {1'b0, divisor}) begin
        t        = t - {1'b0, divisor};
        q_out[i] = 1'b1;
      end
      r = t[DIVISOR_W-1:0];
    end
    rem_out = r;
  end

endmodule

`default_nettype wire

/* rtl/core/taylor_sine_cosine_core.sv */
// Taylor-series sine / cosine, fixed point.
//
// Input channel in_*: in_tdata[31:0] is the signed angle (FRAC_BITS fraction
// bits), in_tuser selects sine (0) or cosine (1). Result channel out_*:
// out_tdata[39:0] is the signed, saturated series sum, out_tuser is the
// overflow flag. cfg_wr_en / cfg_wr_data set the term count (1..MAX_TERMS,
// 0 acts as 1, larger values act as MAX_TERMS); write it only while idle.
//
// One item at a time. A beat is taken in the idle state; the angle is
// squared on the shared 32x32 multiplier, then every further term runs
// four partial products on that multiplier plus one accumulate, a 56-bit
// divide by the series divisor at 8 quotient bits per cycle, and the sum
// update. A term that saturates ends the series early. Once the result is
// registered the sequencer is idle again and takes the next beat.
// The result sits in an output register, so a new beat is accepted while
// it waits; if the receiver stalls, the next result holds in the sequencer
// until the register frees up. Reset sets the term count to 10 and empties
// the output register.
`default_nettype none

module taylor_sine_cosine_core import tsc_pkg::*; #(
  parameter int MAX_TERMS = 10,
  parameter int FRAC_BITS = 28
) (
  input  wire                clk,
  input  wire                rst_n,
  // configuration: term_count
  input  wire                cfg_wr_en,
  input  wire  [TERM_W-1:0]  cfg_wr_data,
  // input stream
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [ANGLE_W-1:0] in_tdata,   // [31:0] angle
  input  wire                in_tuser,   // [0] cmd
  // result stream
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [39:0] value
  output logic               out_tuser   // [0] overflow
);

  // x^2 >> FRAC_BITS width and full product width of mag * x2
  localparam int XW = 2 * ANGLE_W - 1 - FRAC_BITS;
  localparam int PW = MAG_W + XW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_SQRW = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic signed [ACC_W-1:0] ACC_VMAX =
    {{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_VMIN =
    {{(ACC_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

  logic [2:0]              state_r, state_nxt;
  logic [TERM_W-1:0]       term_count_r;
  logic [TERM_W-1:0]       n_r, n_nxt;
  logic [TERM_W-1:0]       k_r, k_nxt;
  logic                    cos_r, cos_nxt;
  logic                    first_neg_r, first_neg_nxt;
  logic [ANGLE_W-1:0]      ax_r, ax_nxt;
  logic [XW-1:0]           x2_r, x2_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [2:0]              j_r, j_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic [DIV_W-1:0]        div_r, div_nxt;
  logic [DIVISOR_W-1:0]    rem_r, rem_nxt;
  logic                    big_r, big_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]      out_data_r, out_data_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [2*MUL_W-1:0]      mul_p;
  logic [1:0]              pj;
  logic [PW-1:0]           part;
  logic [PW-1:0]           prod_sum;
  logic [DIVISOR_W-1:0]    divisor;
  logic [DIVISOR_W-1:0]    dstep_rem;
  logic [DIGIT_W-1:0]      dstep_q;
  logic                    contrib_neg;
  logic                    capped;
  logic signed [ACC_W-1:0] mag_ext;
  logic [ANGLE_W-1:0]      in_ax;
  logic [TERM_W-1:0]       n_clamp;
  logic                    out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  // Term count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_W'(10);
    end else if (cfg_wr_en) begin
      term_count_r <= cfg_wr_data;
    end
  end

  // Shared multiplier operand select
  assign pj = 2'(j_r - 3'd1);
  always_comb begin
    mul_a = ax_r;
    mul_b = ax_r;
    if (state_r == S_MUL) begin
      mul_a = j_r[1] ? MUL_W'(mag_r[MAG_W-1:MUL_W]) : mag_r[MUL_W-1:0];
      mul_b = j_r[0] ? MUL_W'(x2_r[XW-1:MUL_W])     : x2_r[MUL_W-1:0];
    end
  end

  tsc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Partial product alignment: 0, 32 or 64 bits
  always_comb begin
    case (pj)
      2'b00:   part = PW'(mul_p);
      2'b01,
      2'b10:   part = PW'(mul_p) << MUL_W;
      2'b11:   part = PW'(mul_p) << (2 * MUL_W);
      default: part = '0;
    endcase
  end
  assign prod_sum = prod_r + part;

  assign divisor = series_divisor(k_r, cos_r);

  tsc_div_step u_div_step (
    .rem_in  (rem_r),
    .bits_in (div_r[DIV_W-1 -: DIGIT_W]),
    .divisor (divisor),
    .rem_out (dstep_rem),
    .q_out   (dstep_q)
  );

  assign contrib_neg = first_neg_r ^ ~k_r[0];
  assign capped      = big_r | (|div_r[DIV_W-1:MAG_W]);
  assign mag_ext     = ACC_W'(div_r[MAG_W-1:0]);
  assign in_ax       = in_tdata[ANGLE_W-1] ? (~in_tdata + ANGLE_W'(1)) : in_tdata;
  assign n_clamp     = (term_count_r == '0) ? TERM_W'(1) :
                       (term_count_r > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) :
                       term_count_r;
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    cos_nxt       = cos_r;
    first_neg_nxt = first_neg_r;
    ax_nxt        = ax_r;
    x2_nxt        = x2_r;
    mag_nxt       = mag_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    j_nxt         = j_r;
    prod_nxt      = prod_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    big_nxt       = big_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt         = n_clamp;
          k_nxt         = TERM_W'(2);
          cos_nxt       = in_tuser;
          first_neg_nxt = !in_tuser && in_tdata[ANGLE_W-1];
          ax_nxt        = in_ax;
          ovf_nxt       = 1'b0;
          if (in_tuser) begin
            mag_nxt = MAG_W'(1) << FRAC_BITS;
            acc_nxt = ACC_W'(1) << FRAC_BITS;
          end else begin
            mag_nxt = MAG_W'(in_ax);
            acc_nxt = in_tdata[ANGLE_W-1] ? -ACC_W'(in_ax) : ACC_W'(in_ax);
          end
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        state_nxt = S_SQRW;
      end
      S_SQRW: begin
        x2_nxt    = XW'(mul_p >> FRAC_BITS);
        j_nxt     = 3'd0;
        prod_nxt  = '0;
        state_nxt = (n_r == TERM_W'(1)) ? S_FIN : S_MUL;
      end
      // four partial products, each accumulated in the cycle after its issue
      S_MUL: begin
        if (j_r != 3'd0) begin
          prod_nxt = prod_sum;
        end
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd4) begin
          div_nxt   = DIV_W'(prod_sum >> FRAC_BITS);
          big_nxt   = |(prod_sum >> (FRAC_BITS + DIV_W));
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_nxt  = {div_r[DIV_W-DIGIT_W-1:0], dstep_q};
        rem_nxt  = dstep_rem;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (capped) begin
          ovf_nxt   = 1'b1;
          acc_nxt   = contrib_neg ? ACC_VMIN : ACC_VMAX;
          state_nxt = S_FIN;
        end else begin
          mag_nxt  = div_r[MAG_W-1:0];
          acc_nxt  = contrib_neg ? (acc_r - mag_ext) : (acc_r + mag_ext);
          j_nxt    = 3'd0;
          prod_nxt = '0;
          if (k_r == n_r) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt     = k_r + TERM_W'(1);
            state_nxt = S_MUL;
          end
        end
      end
      // saturate and hand over to the output register
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (acc_r > ACC_VMAX) begin
            out_data_nxt = ACC_VMAX[VALUE_W-1:0];
            out_ovf_nxt  = 1'b1;
          end else if (acc_r < ACC_VMIN) begin
            out_data_nxt = ACC_VMIN[VALUE_W-1:0];
            out_ovf_nxt  = 1'b1;
          end else begin
            out_data_nxt = acc_r[VALUE_W-1:0];
            out_ovf_nxt  = ovf_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= 3'd0;
      step_r      <= '0;
      k_r         <= TERM_W'(2);
      n_r         <= TERM_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cos_r       <= cos_nxt;
    first_neg_r <= first_neg_nxt;
    ax_r        <= ax_nxt;
    x2_r        <= x2_nxt;
    mag_r       <= mag_nxt;
    acc_r       <= acc_nxt;
    ovf_r       <= ovf_nxt;
    prod_r      <= prod_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    big_r       <= big_nxt;
    out_data_r  <= out_data_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SQR))
    else $error("accepted beat did not start the square step");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < divisor))
    else $error("divider remainder not below divisor");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV || state_r == S_UPD) |->
      (k_r >= TERM_W'(2) && k_r <= n_r && n_r <= TERM_W'(MAX_TERMS)))
    else $error("term index out of range");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |->
      (out_data_r == ACC_VMAX[VALUE_W-1:0] || out_data_r == ACC_VMIN[VALUE_W-1:0]))
    else $error("overflow flagged but value not at a range limit");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=>
      (state_r == S_FIN && out_valid_r))
    else $error("result lost while output register was full");

endmodule

`default_nettype wire
